>>> sv/touch_sample_filter_and_map_macros.svh
// Assertion macros shared by the touch sample filter and map block
`ifndef TOUCH_SAMPLE_FILTER_AND_MAP_MACROS_SVH
`define TOUCH_SAMPLE_FILTER_AND_MAP_MACROS_SVH

// Check an expression on every clock edge outside reset
`define TSFM_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define TSFM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> sv/tsfm_pkg.sv
// Shared types, codes and constants of the touch sample filter and map block
`default_nettype none

package tsfm_pkg;

   // Default parameter values
   localparam int DEF_SAMPLES    = 6;
   localparam int DEF_MAX_SPREAD = 50;

   // Sample and field widths
   localparam int SAMPLE_W = 13;
   localparam int GAIN_W   = 24;
   localparam int OFFSET_W = 16;
   localparam int FRAC_W   = 22;
   localparam int PIXEL_W  = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   // Screen limits for the off-screen test
   localparam logic [PIXEL_W-1:0] SCREEN_X_LIMIT = 8'd128;
   localparam logic [PIXEL_W-1:0] SCREEN_Y_LIMIT = 8'd160;
   localparam logic [PIXEL_W-1:0] PIXEL_MAX      = 8'hFF;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OFFSCREEN = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_X_MIN = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_X_MAX = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_Y_MIN = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_Y_MAX = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_X    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Y    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y  = 4'd7;

   // Group order within one point
   localparam logic [1:0] GROUP_Y2 = 2'd3;

   // Group close handed from the accumulator to the mean stage
   typedef struct packed {
      logic       valid;
      logic [1:0] group;
   } close_type;

   // Raw acceptance window
   typedef struct packed {
      logic [SAMPLE_W-1:0] x_min;
      logic [SAMPLE_W-1:0] x_max;
      logic [SAMPLE_W-1:0] y_min;
      logic [SAMPLE_W-1:0] y_max;
   } window_type;

   // Linear calibration
   typedef struct packed {
      logic signed [GAIN_W-1:0]   gain_x;
      logic signed [GAIN_W-1:0]   gain_y;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
   } calib_type;

   // Averaged point handed from the mean stage to the mapper
   typedef struct packed {
      logic                valid;
      logic                reject;
      logic [SAMPLE_W-1:0] raw_x;
      logic [SAMPLE_W-1:0] raw_y;
   } point_type;

   // Result fields
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PIXEL_W-1:0]  pixel_x;
      logic [PIXEL_W-1:0]  pixel_y;
      logic [SAMPLE_W-1:0] raw_x;
      logic [SAMPLE_W-1:0] raw_y;
   } result_type;

endpackage

`default_nettype wire

>>> sv/tsfm_accum.sv
// Running sum, minimum and maximum of each sample group, closed into a trimmed numerator
`default_nettype none

module tsfm_accum #(
   parameter int SAMPLES = tsfm_pkg::DEF_SAMPLES,
   parameter int SUM_W   = tsfm_pkg::SAMPLE_W + $clog2(SAMPLES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [15:0]           raw_word,
   output tsfm_pkg::close_type        close,
   output logic [SUM_W-1:0]           close_num,
   output logic                       point_closing
);
   import tsfm_pkg::*;

   localparam int CNT_W = $clog2(SAMPLES);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [1:0]          group_ff, group_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   close_type           close_ff, close_in;
   logic [SUM_W-1:0]    num_ff, num_in;

   logic [SAMPLE_W-1:0] sample;
   logic [SUM_W-1:0]    sum_new;
   logic [SAMPLE_W-1:0] min_new;
   logic [SAMPLE_W-1:0] max_new;
   logic                last;

   // Fold the new sample into the running values
   assign sample  = raw_word[15:3];
   assign sum_new = sum_ff + SUM_W'(sample);
   assign min_new = (sample < min_ff) ? sample : min_ff;
   assign max_new = (sample > max_ff) ? sample : max_ff;
   assign last    = (count_ff == CNT_W'(SAMPLES - 1));

   always_comb begin
      count_in       = count_ff;
      group_in       = group_ff;
      sum_in         = sum_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      close_in.valid = 1'b0;
      close_in.group = group_ff;
      num_in         = sum_new - SUM_W'(min_new) - SUM_W'(max_new);
      if (accept) begin
         if (last) begin
            // Close the group and start the next one
            count_in       = '0;
            group_in       = group_ff + 2'd1;
            sum_in         = '0;
            min_in         = '1;
            max_in         = '0;
            close_in.valid = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_new;
            min_in   = min_new;
            max_in   = max_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         group_ff       <= '0;
         sum_ff         <= '0;
         min_ff         <= '1;
         max_ff         <= '0;
         close_ff.valid <= 1'b0;
      end else begin
         count_ff       <= count_in;
         group_ff       <= group_in;
         sum_ff         <= sum_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         close_ff.valid <= close_in.valid;
      end
      close_ff.group <= close_in.group;
      num_ff         <= num_in;
   end

   assign close         = close_ff;
   assign close_num     = num_ff;
   // Next accepted request completes a point
   assign point_closing = last && (group_ff == GROUP_Y2);

endmodule

`default_nettype wire

>>> sv/tsfm_mean.sv
// Group mean by reciprocal multiply, mean storage, stability and window checks
`default_nettype none

module tsfm_mean #(
   parameter int SAMPLES    = tsfm_pkg::DEF_SAMPLES,
   parameter int MAX_SPREAD = tsfm_pkg::DEF_MAX_SPREAD,
   parameter int SUM_W      = tsfm_pkg::SAMPLE_W + $clog2(SAMPLES)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tsfm_pkg::close_type close,
   input  wire logic [SUM_W-1:0]    close_num,
   input  wire tsfm_pkg::window_type window,
   output tsfm_pkg::point_type      point
);
   import tsfm_pkg::*;

   // Floor division by the trimmed count: exact for every numerator below 2**SUM_W
   localparam int DIV   = SAMPLES - 2;
   localparam int SH    = SUM_W + $clog2(DIV);
   localparam logic [SH:0] RECIP = (SH+1)'((2 ** SH + DIV - 1) / DIV);
   localparam int PW    = SUM_W + SH + 1;

   logic [PW-1:0]       prod_ff, prod_in;
   close_type           grp_ff;
   logic [SAMPLE_W-1:0] means_ff [0:2];
   point_type           point_ff, point_in;

   logic [SAMPLE_W-1:0] mean;
   logic [SAMPLE_W-1:0] x1, y1, x2, y2;
   logic [SAMPLE_W:0]   sum_x, sum_y;
   logic [SAMPLE_W-1:0] diff_x, diff_y;
   logic [SAMPLE_W-1:0] spread;

   // Multiply the numerator by the reciprocal
   assign prod_in = {{(SH+1){1'b0}}, close_num} * {{SUM_W{1'b0}}, RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff.valid <= 1'b0;
      end else begin
         grp_ff.valid <= close.valid;
      end
      grp_ff.group <= close.group;
      prod_ff      <= prod_in;
   end

   assign mean = prod_ff[SH +: SAMPLE_W];

   // Keep the first three group means of a point
   always_ff @(posedge clock) begin
      if (grp_ff.valid && (grp_ff.group != GROUP_Y2)) begin
         means_ff[grp_ff.group] <= mean;
      end
   end

   // Average both pairs and test spread and window
   assign x1     = means_ff[0];
   assign y1     = means_ff[1];
   assign x2     = means_ff[2];
   assign y2     = mean;
   assign sum_x  = {1'b0, x1} + {1'b0, x2};
   assign sum_y  = {1'b0, y1} + {1'b0, y2};
   assign diff_x = (x1 > x2) ? (x1 - x2) : (x2 - x1);
   assign diff_y = (y1 > y2) ? (y1 - y2) : (y2 - y1);
   assign spread = SAMPLE_W'(MAX_SPREAD);

   always_comb begin
      point_in.valid  = grp_ff.valid && (grp_ff.group == GROUP_Y2);
      point_in.raw_x  = sum_x[SAMPLE_W:1];
      point_in.raw_y  = sum_y[SAMPLE_W:1];
      point_in.reject = (diff_x > spread) || (diff_y > spread) ||
                        (point_in.raw_x < window.x_min) || (point_in.raw_x > window.x_max) ||
                        (point_in.raw_y < window.y_min) || (point_in.raw_y > window.y_max);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff.valid <= 1'b0;
      end else begin
         point_ff.valid <= point_in.valid;
      end
      point_ff.reject <= point_in.reject;
      point_ff.raw_x  <= point_in.raw_x;
      point_ff.raw_y  <= point_in.raw_y;
   end

   assign point = point_ff;

endmodule

`default_nettype wire

>>> sv/tsfm_map.sv
// Linear mapping of the averaged point to pixels, clamping and screen test
`default_nettype none

module tsfm_map (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tsfm_pkg::point_type point,
   input  wire tsfm_pkg::calib_type calib,
   output logic                     res_valid,
   output tsfm_pkg::result_type     result
);
   import tsfm_pkg::*;

   localparam int PROD_W = SAMPLE_W + 1 + GAIN_W;
   localparam int ACC_W  = OFFSET_W + FRAC_W + 2;

   logic signed [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   point_type                pt_ff;

   logic signed [ACC_W-1:0]  acc_x, acc_y;
   logic [PIXEL_W-1:0]       px, py;

   // Clamp a Q.22 value, truncated toward zero, to the pixel range
   function automatic logic [PIXEL_W-1:0] clamp_pixel(input logic signed [ACC_W-1:0] acc);
      logic [PIXEL_W-1:0] pix;
      if (acc[ACC_W-1]) begin
         pix = '0;
      end else if (|acc[ACC_W-2:FRAC_W+PIXEL_W]) begin
         pix = PIXEL_MAX;
      end else begin
         pix = acc[FRAC_W +: PIXEL_W];
      end
      return pix;
   endfunction

   // Scale both axes
   assign prod_x_in = $signed({1'b0, point.raw_x}) * calib.gain_x;
   assign prod_y_in = $signed({1'b0, point.raw_y}) * calib.gain_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff.valid <= 1'b0;
      end else begin
         pt_ff.valid <= point.valid;
      end
      pt_ff.reject <= point.reject;
      pt_ff.raw_x  <= point.raw_x;
      pt_ff.raw_y  <= point.raw_y;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
   end

   // Add the offsets and clamp
   assign acc_x = {{(ACC_W-PROD_W){prod_x_ff[PROD_W-1]}}, prod_x_ff} +
                  {{(ACC_W-OFFSET_W-FRAC_W){calib.offset_x[OFFSET_W-1]}},
                   calib.offset_x, {FRAC_W{1'b0}}};
   assign acc_y = {{(ACC_W-PROD_W){prod_y_ff[PROD_W-1]}}, prod_y_ff} +
                  {{(ACC_W-OFFSET_W-FRAC_W){calib.offset_y[OFFSET_W-1]}},
                   calib.offset_y, {FRAC_W{1'b0}}};
   assign px = clamp_pixel(acc_x);
   assign py = clamp_pixel(acc_y);

   always_comb begin
      result.raw_x = pt_ff.raw_x;
      result.raw_y = pt_ff.raw_y;
      if (pt_ff.reject) begin
         result.status  = STATUS_REJECT;
         result.pixel_x = '0;
         result.pixel_y = '0;
      end else begin
         result.pixel_x = px;
         result.pixel_y = py;
         if ((px > SCREEN_X_LIMIT) || (py > SCREEN_Y_LIMIT)) begin
            result.status = STATUS_OFFSCREEN;
         end else begin
            result.status = STATUS_OK;
         end
      end
   end

   assign res_valid = pt_ff.valid;

endmodule

`default_nettype wire

>>> sv/touch_sample_filter_and_map.sv
// Top level of the touch sample filter and map block
//
// Request channel (req_valid, req_stall, req_raw_word) carries one raw controller
// word per request; the sample is the word shifted right by three. Requests come
// in four groups of SAMPLES: X, Y, X, Y. Each group loses its smallest and largest
// sample and keeps the floor mean of the rest. After the fourth group one result
// leaves on the response channel (rsp_valid, rsp_stall, rsp_status, rsp_pixel_*,
// rsp_raw_*). One request is taken per cycle while req_stall is low. The result
// passes through five registers, the first loaded by the edge that accepts the
// last request of a point: the group close register, the reciprocal multiply,
// the check register, the gain multiply and the output register. A stalled result
// holds in the output register; requests keep flowing, except the one that would
// close the next point, which waits until the held result is taken. Registers are
// written through csr_valid, csr_index and csr_data; csr_ready is always high and
// an index above 7 is ignored. Synchronous reset clears the group state and loads
// the register reset values: an open window and zero gains and offsets.
`default_nettype none
`include "touch_sample_filter_and_map_macros.svh"

module touch_sample_filter_and_map #(
   parameter int SAMPLES    = tsfm_pkg::DEF_SAMPLES,
   parameter int MAX_SPREAD = tsfm_pkg::DEF_MAX_SPREAD
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [15:0]                         req_raw_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [tsfm_pkg::STATUS_W-1:0]            rsp_status,
   output logic [tsfm_pkg::PIXEL_W-1:0]             rsp_pixel_x,
   output logic [tsfm_pkg::PIXEL_W-1:0]             rsp_pixel_y,
   output logic [tsfm_pkg::SAMPLE_W-1:0]            rsp_raw_x,
   output logic [tsfm_pkg::SAMPLE_W-1:0]            rsp_raw_y,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tsfm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tsfm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tsfm_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);

   window_type  window_ff, window_in;
   calib_type   calib_ff, calib_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        accept;
   logic        point_closing;
   close_type   close;
   logic [SUM_W-1:0] close_num;
   point_type   point;
   logic        map_valid;
   result_type  map_result;

   logic        rsp_held;
   logic        rsp_reject;
   logic        rsp_offscreen;
   logic        rsp_zero_pix;
   logic        rsp_past_edge;

   // Hold the closing request while a result still waits
   assign req_stall = point_closing && rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      window_in = window_ff;
      calib_in  = calib_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RAW_X_MIN: window_in.x_min    = csr_data[SAMPLE_W-1:0];
            CSR_RAW_X_MAX: window_in.x_max    = csr_data[SAMPLE_W-1:0];
            CSR_RAW_Y_MIN: window_in.y_min    = csr_data[SAMPLE_W-1:0];
            CSR_RAW_Y_MAX: window_in.y_max    = csr_data[SAMPLE_W-1:0];
            CSR_GAIN_X:    calib_in.gain_x    = csr_data[GAIN_W-1:0];
            CSR_GAIN_Y:    calib_in.gain_y    = csr_data[GAIN_W-1:0];
            CSR_OFFSET_X:  calib_in.offset_x  = csr_data[OFFSET_W-1:0];
            CSR_OFFSET_Y:  calib_in.offset_y  = csr_data[OFFSET_W-1:0];
            default: begin
               window_in = window_ff;
               calib_in  = calib_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.x_min   <= '0;
         window_ff.x_max   <= '1;
         window_ff.y_min   <= '0;
         window_ff.y_max   <= '1;
         calib_ff.gain_x   <= '0;
         calib_ff.gain_y   <= '0;
         calib_ff.offset_x <= '0;
         calib_ff.offset_y <= '0;
      end else begin
         window_ff <= window_in;
         calib_ff  <= calib_in;
      end
   end

   tsfm_accum #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .raw_word      (req_raw_word),
      .close         (close),
      .close_num     (close_num),
      .point_closing (point_closing)
   );

   tsfm_mean #(
      .SAMPLES    (SAMPLES),
      .MAX_SPREAD (MAX_SPREAD),
      .SUM_W      (SUM_W)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .close     (close),
      .close_num (close_num),
      .window    (window_ff),
      .point     (point)
   );

   tsfm_map u_map (
      .clock     (clock),
      .reset     (reset),
      .point     (point),
      .calib     (calib_ff),
      .res_valid (map_valid),
      .result    (map_result)
   );

   // Output register: load a new result, drop a delivered one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (map_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = map_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_ff.status;
   assign rsp_pixel_x = rsp_ff.pixel_x;
   assign rsp_pixel_y = rsp_ff.pixel_y;
   assign rsp_raw_x   = rsp_ff.raw_x;
   assign rsp_raw_y   = rsp_ff.raw_y;

   // Result conditions watched by the checks below
   assign rsp_held      = rsp_valid_ff && rsp_stall;
   assign rsp_reject    = rsp_valid_ff && (rsp_ff.status == STATUS_REJECT);
   assign rsp_offscreen = rsp_valid_ff && (rsp_ff.status == STATUS_OFFSCREEN);
   assign rsp_zero_pix  = (rsp_ff.pixel_x == '0) && (rsp_ff.pixel_y == '0);
   assign rsp_past_edge = (rsp_ff.pixel_x > SCREEN_X_LIMIT) ||
                          (rsp_ff.pixel_y > SCREEN_Y_LIMIT);

   // A new result never lands on a held one
   `TSFM_ASSERT_IMP(a_no_overrun, map_valid, !rsp_held, "result overran a held result")
   // A rejected point carries zero pixels
   `TSFM_ASSERT_IMP(a_reject_zero, rsp_reject, rsp_zero_pix, "rejected point has nonzero pixels")
   // An off-screen flag matches the clamped pixels
   `TSFM_ASSERT_IMP(a_offscreen, rsp_offscreen, rsp_past_edge, "off-screen flag on on-screen point")

endmodule

`default_nettype wire

>>> bench/tb_touch_sample_filter_and_map.sv
// Self-checking testbench for the touch sample filter and map block
`default_nettype none

module tb_touch_sample_filter_and_map;
   import tsfm_pkg::*;

   localparam int SAMPLES      = DEF_SAMPLES;
   localparam int MAX_SPREAD   = DEF_MAX_SPREAD;
   localparam int SAMPLE_TOP   = (1 << SAMPLE_W) - 1;
   localparam int DRAIN_CYCLES = 8;
   localparam int JITTER       = 6;
   localparam int IDLE_PERCENT = 11;
   localparam int GAIN_MIN     = -(1 << (GAIN_W - 1));
   localparam int GAIN_MAX     = (1 << (GAIN_W - 1)) - 1;
   localparam int OFFSET_MIN   = -(1 << (OFFSET_W - 1));
   localparam int OFFSET_MAX   = (1 << (OFFSET_W - 1)) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd15;

   typedef enum {POINT_STABLE, POINT_SPREAD, POINT_NOISE} point_kind_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_raw_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PIXEL_W-1:0] rsp_pixel_x;
   logic [PIXEL_W-1:0] rsp_pixel_y;
   logic [SAMPLE_W-1:0] rsp_raw_x;
   logic [SAMPLE_W-1:0] rsp_raw_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predictor state: group accumulator, stored means and register copies
   int acc_count = 0;
   int acc_sum = 0;
   int acc_min = SAMPLE_TOP;
   int acc_max = 0;
   logic [1:0] group_sel = '0;
   int group_mean [3];
   window_type window = '{x_min: '0, x_max: '1, y_min: '0, y_max: '1};
   calib_type calib = '0;

   result_type pending_points [$];
   int error_count = 0;
   bit calm = 1'b0;

   touch_sample_filter_and_map dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_raw_word (req_raw_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_raw_x    (rsp_raw_x),
      .rsp_raw_y    (rsp_raw_y),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bound the run
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   task automatic flag_error(input string msg);
      $display("tb: %s", msg);
      error_count++;
   endtask

   function automatic int mean_gap(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Map one raw axis: raw * gain + offset, truncate toward zero, clamp to a byte
   function automatic int scale_axis(input int raw, input logic signed [GAIN_W-1:0] gain,
                                     input logic signed [OFFSET_W-1:0] offset);
      longint one_q;
      longint acc;
      longint q;
      one_q = longint'(1) <<< FRAC_W;
      acc = longint'(raw) * longint'(gain) + longint'(offset) * one_q;
      q = acc / one_q;
      if (q < 0)
         return 0;
      if (q > 255)
         return int'(PIXEL_MAX);
      return int'(q);
   endfunction

   // Fold one accepted sample into the group and predict the point when Y2 closes
   task automatic filter_sample(input logic [15:0] word);
      int s;
      int mean;
      int rx;
      int ry;
      int px;
      int py;
      result_type r;
      s = int'(word[15:3]);
      acc_sum += s;
      if (s < acc_min)
         acc_min = s;
      if (s > acc_max)
         acc_max = s;
      acc_count++;
      if (acc_count < SAMPLES)
         return;

      // Drop one minimum and one maximum, keep the floor mean
      mean = (acc_sum - acc_min - acc_max) / (SAMPLES - 2);
      acc_count = 0;
      acc_sum = 0;
      acc_min = SAMPLE_TOP;
      acc_max = 0;
      if (group_sel != GROUP_Y2) begin
         group_mean[group_sel] = mean;
         group_sel++;
         return;
      end
      group_sel = '0;

      rx = (group_mean[0] + group_mean[2]) / 2;
      ry = (group_mean[1] + mean) / 2;
      r.raw_x = SAMPLE_W'(rx);
      r.raw_y = SAMPLE_W'(ry);
      r.pixel_x = '0;
      r.pixel_y = '0;
      if (mean_gap(group_mean[0], group_mean[2]) > MAX_SPREAD ||
          mean_gap(group_mean[1], mean) > MAX_SPREAD ||
          rx < window.x_min || rx > window.x_max ||
          ry < window.y_min || ry > window.y_max) begin
         r.status = STATUS_REJECT;
      end else begin
         px = scale_axis(rx, calib.gain_x, calib.offset_x);
         py = scale_axis(ry, calib.gain_y, calib.offset_y);
         r.pixel_x = PIXEL_W'(px);
         r.pixel_y = PIXEL_W'(py);
         r.status = (px > SCREEN_X_LIMIT || py > SCREEN_Y_LIMIT) ? STATUS_OFFSCREEN : STATUS_OK;
      end
      pending_points.push_back(r);
   endtask

   // Send one request, with random idle cycles ahead of it
   task automatic send_word(input logic [15:0] word);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_word <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      filter_sample(word);
   endtask

   // Send one group of samples around a center, optionally with one wild spike
   task automatic send_group(input int center, input bit spike);
      int k;
      int v;
      int spike_at;
      spike_at = $urandom_range(SAMPLES - 1);
      for (k = 0; k < SAMPLES; k++) begin
         v = center + int'($urandom_range(2 * JITTER)) - JITTER;
         if (spike && k == spike_at)
            v = $urandom_range(SAMPLE_TOP);
         if (v < 0)
            v = 0;
         if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
         send_word({13'(v), 3'($urandom)});
      end
   endtask

   // Send random points: mostly stable, some near the spread limit, some pure noise
   task automatic run_points(input int n, input int x_lo, input int x_hi,
                             input int y_lo, input int y_hi);
      int p;
      int k;
      int pick;
      int cx;
      int cy;
      int span;
      point_kind_type kind;
      for (p = 0; p < n; p++) begin
         pick = $urandom_range(99);
         kind = (pick < 70) ? POINT_STABLE : (pick < 90) ? POINT_SPREAD : POINT_NOISE;
         cx = $urandom_range(x_hi, x_lo);
         cy = $urandom_range(y_hi, y_lo);
         if ($urandom_range(15) == 0)
            cx = $urandom_range(1) ? SAMPLE_TOP : 0;
         if ($urandom_range(15) == 0)
            cy = $urandom_range(1) ? SAMPLE_TOP : 0;
         if (kind == POINT_NOISE) begin
            for (k = 0; k < 4 * SAMPLES; k++)
               send_word(16'($urandom));
         end else begin
            span = (kind == POINT_STABLE) ? 20 : 70;
            send_group(cx, $urandom_range(3) == 0);
            send_group(cy, $urandom_range(3) == 0);
            send_group(cx + int'($urandom_range(2 * span)) - span, $urandom_range(3) == 0);
            send_group(cy + int'($urandom_range(2 * span)) - span, $urandom_range(3) == 0);
         end
      end
   endtask

   // Drop valid, wait for every pending point, then let the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register and mirror it into the predictor
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_RAW_X_MIN: window.x_min = data[SAMPLE_W-1:0];
         CSR_RAW_X_MAX: window.x_max = data[SAMPLE_W-1:0];
         CSR_RAW_Y_MIN: window.y_min = data[SAMPLE_W-1:0];
         CSR_RAW_Y_MAX: window.y_max = data[SAMPLE_W-1:0];
         CSR_GAIN_X:    calib.gain_x = data[GAIN_W-1:0];
         CSR_GAIN_Y:    calib.gain_y = data[GAIN_W-1:0];
         CSR_OFFSET_X:  calib.offset_x = data[OFFSET_W-1:0];
         CSR_OFFSET_Y:  calib.offset_y = data[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   // Load a full setting once idle; upper data bits carry junk to check masking
   task automatic load_settings(input int x_min, input int x_max, input int y_min,
                                input int y_max, input int gx, input int gy,
                                input int ox, input int oy);
      wait_drained();
      write_reg(CSR_RAW_X_MIN, {11'($urandom), 13'(x_min)});
      write_reg(CSR_RAW_X_MAX, {11'($urandom), 13'(x_max)});
      write_reg(CSR_RAW_Y_MIN, {11'($urandom), 13'(y_min)});
      write_reg(CSR_RAW_Y_MAX, {11'($urandom), 13'(y_max)});
      write_reg(CSR_GAIN_X, 24'(gx));
      write_reg(CSR_GAIN_Y, 24'(gy));
      write_reg(CSR_OFFSET_X, {8'($urandom), 16'(ox)});
      write_reg(CSR_OFFSET_Y, {8'($urandom), 16'(oy)});
      write_reg(CSR_UNUSED, 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Reset defaults: field extremes, ignored low bits, equal samples, a spread reject
   task automatic test_trimmed_extremes();
      logic [15:0] words [24] = '{
         16'h0000, 16'hFFFF, 16'h8000, 16'h8007, 16'h8000, 16'h8003,
         16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
         16'h7FF8, 16'h8008, 16'h8000, 16'h8000, 16'hFFFF, 16'h0007,
         16'h4000, 16'h4000, 16'h5555, 16'h4000, 16'hAAAA, 16'h4000};
      int k;
      for (k = 0; k < 24; k++)
         send_word(words[k]);
   endtask

   // Roughly full-scale gain so points land on and off the screen
   task automatic test_linear_map();
      load_settings(0, SAMPLE_TOP, 0, SAMPLE_TOP,
                    120000 + $urandom_range(20000), 120000 + $urandom_range(20000),
                    int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20);
      run_points(16, 0, SAMPLE_TOP, 0, SAMPLE_TOP);
   endtask

   // Narrow windows with points drawn across and just past their edges
   task automatic test_window_edges();
      load_settings(1000, 3000, 5000, 7000, 180000, 90000, -40, -400);
      run_points(14, 800, 3200, 4800, 7200);
   endtask

   // Extreme gains and offsets drive the clamp both ways
   task automatic test_clamp_extremes();
      load_settings(0, SAMPLE_TOP, 0, SAMPLE_TOP, GAIN_MIN, GAIN_MAX, OFFSET_MAX, OFFSET_MIN);
      run_points(6, 0, SAMPLE_TOP, 0, SAMPLE_TOP);
      load_settings(0, SAMPLE_TOP, 0, SAMPLE_TOP, GAIN_MAX, GAIN_MIN, OFFSET_MIN, OFFSET_MAX);
      run_points(6, 0, SAMPLE_TOP, 0, SAMPLE_TOP);
   endtask

   // Inverted X window rejects every point
   task automatic test_inverted_window();
      load_settings(SAMPLE_TOP, 0, 0, SAMPLE_TOP, 200000, 200000, 0, 0);
      run_points(6, 0, SAMPLE_TOP, 0, SAMPLE_TOP);
   endtask

   // Long stretch with no idling on either side
   task automatic test_back_to_back();
      load_settings(200, 8000, 100, 8100, 130000, 100000, 5, -5);
      calm = 1'b1;
      run_points(14, 0, SAMPLE_TOP, 0, SAMPLE_TOP);
      wait_drained();
      calm = 1'b0;
   endtask

   // Several random settings
   task automatic test_random_settings();
      int n;
      for (n = 0; n < 3; n++) begin
         load_settings($urandom_range(3000), $urandom_range(SAMPLE_TOP, 5000),
                       $urandom_range(3000), $urandom_range(SAMPLE_TOP, 5000),
                       $urandom, $urandom, $urandom, $urandom);
         run_points(5, 0, SAMPLE_TOP, 0, SAMPLE_TOP);
      end
   endtask

   // Random result stall
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         flag_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
   endtask

   // Compare each accepted result with the oldest pending point
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            flag_error("result with no point pending");
         end else begin
            want = pending_points.pop_front();
            check_field("status", rsp_status, want.status);
            check_field("pixel_x", rsp_pixel_x, want.pixel_x);
            check_field("pixel_y", rsp_pixel_y, want.pixel_y);
            check_field("raw_x", rsp_raw_x, want.raw_x);
            check_field("raw_y", rsp_raw_y, want.raw_y);
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_trimmed_extremes();
      test_linear_map();
      test_window_edges();
      test_clamp_extremes();
      test_inverted_window();
      test_back_to_back();
      test_random_settings();
      wait_drained();
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
